// ===== sv/wpa_pkg.sv =====
package wpa_pkg;

  localparam int MAX_LEN_DEF  = 128;
  localparam int MAX_TAPS_DEF = 8;
  localparam int SAMPLE_W_DEF = 16;

  localparam int COEF_W      = 35;
  localparam int COEFF_IDX_W = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 8;
  localparam int TAPCNT_W    = 4;
  localparam int TAP_W       = 16;
  localparam int TAP_SEL_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN   = 3'd5;

  localparam logic [CFG_DATA_W-1:0] LOW_FIRST_RST  = 64'd1073758208;
  localparam logic [CFG_DATA_W-1:0] HIGH_FIRST_RST = 64'd1073790976;
  localparam logic [TAPCNT_W-1:0]   TAP_COUNT_RST  = 4'd2;
  localparam logic [LEN_W-1:0]      BLOCK_LEN_RST  = 8'd8;

  // Effective configuration, with tap count and length already clamped.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] low_first;
    logic [CFG_DATA_W-1:0] low_second;
    logic [CFG_DATA_W-1:0] high_first;
    logic [CFG_DATA_W-1:0] high_second;
    logic [TAPCNT_W-1:0]   taps;
    logic [LEN_W-1:0]      len;
  } cfg_t;

  // One multiply-accumulate step as issued by the sequencer.
  typedef struct packed {
    logic                   valid;
    logic                   first;
    logic                   last;
    logic                   zero;
    logic [TAP_SEL_W-1:0]   tap_sel;
    logic [COEFF_IDX_W-1:0] pair;
    logic                   last_pair;
  } mac_ctrl_t;

  function automatic logic signed [TAP_W-1:0] tap_of(input logic [CFG_DATA_W-1:0] first,
                                                     input logic [CFG_DATA_W-1:0] second,
                                                     input logic [TAP_SEL_W-1:0] sel);
    logic [CFG_DATA_W-1:0] word;
    word = sel[2] ? second : first;
    return $signed(word[TAP_W*sel[1:0] +: TAP_W]);
  endfunction

endpackage

// ===== sv/wpa_if.sv =====
interface wpa_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wpa_out_if ();
  logic               valid;
  logic               ready;
  logic signed [34:0] approx;
  logic signed [34:0] detail;
  logic [5:0]         coeff_index;
  logic               last_pair;

  modport source (output valid, output approx, output detail, output coeff_index,
                  output last_pair, input ready);
  modport sink (input valid, input approx, input detail, input coeff_index,
                input last_pair, output ready);
endinterface

interface wpa_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/wpa_cfg_regs.sv =====
module wpa_cfg_regs
  import wpa_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  input  logic [CFG_IDX_W-1:0]  wr_index_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  logic [CFG_DATA_W-1:0] low_first_q, low_second_q, high_first_q, high_second_q;
  logic [TAPCNT_W-1:0]   taps_q;
  logic [LEN_W-1:0]      len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_first_q   <= LOW_FIRST_RST;
      low_second_q  <= '0;
      high_first_q  <= HIGH_FIRST_RST;
      high_second_q <= '0;
      taps_q        <= TAP_COUNT_RST;
      len_q         <= BLOCK_LEN_RST;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        REG_LOW_FIRST:   low_first_q   <= wr_data_i;
        REG_LOW_SECOND:  low_second_q  <= wr_data_i;
        REG_HIGH_FIRST:  high_first_q  <= wr_data_i;
        REG_HIGH_SECOND: high_second_q <= wr_data_i;
        REG_TAP_COUNT:   taps_q        <= wr_data_i[TAPCNT_W-1:0];
        REG_BLOCK_LEN:   len_q         <= wr_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.low_first   = low_first_q;
    cfg_o.low_second  = low_second_q;
    cfg_o.high_first  = high_first_q;
    cfg_o.high_second = high_second_q;
    cfg_o.taps = (taps_q > TAPCNT_W'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS) : taps_q;
    if (len_q < LEN_W'(2)) begin
      cfg_o.len = LEN_W'(2);
    end else if (len_q > LEN_W'(MAX_LEN)) begin
      cfg_o.len = LEN_W'(MAX_LEN);
    end else begin
      cfg_o.len = len_q;
    end
  end

endmodule

// ===== sv/wpa_sample_mem.sv =====
module wpa_sample_mem
  import wpa_pkg::*;
#(
  parameter int DEPTH = MAX_LEN_DEF,
  parameter int WIDTH = SAMPLE_W_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/wpa_dual_mac.sv =====
module wpa_dual_mac
  import wpa_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [COEF_W-1:0]      approx_o,
  output logic signed [COEF_W-1:0]      detail_o,
  output logic [COEFF_IDX_W-1:0]        coeff_index_o,
  output logic                          last_pair_o
);

  localparam int PROD_W = SAMPLE_WIDTH + TAP_W;
  localparam int EXT_W  = (PROD_W > COEF_W) ? PROD_W : COEF_W;

  mac_ctrl_t ctrl1_q, ctrl2_q;

  logic signed [TAP_W-1:0]  tap_lo, tap_hi;
  logic signed [EXT_W-1:0]  prod_lo_d, prod_hi_d, prod_lo_q, prod_hi_q;
  logic signed [COEF_W-1:0] acc_lo_d, acc_hi_d, acc_lo_q, acc_hi_q;

  logic                     out_valid_q;
  logic signed [COEF_W-1:0] approx_q, detail_q;
  logic [COEFF_IDX_W-1:0]   index_q;
  logic                     last_pair_q;

  // Stage 1 lines up with the registered memory read; a zero tap count
  // still runs one step so that both sums come out as zero.
  always_comb begin
    tap_lo = ctrl1_q.zero ? '0 : tap_of(cfg_i.low_first, cfg_i.low_second, ctrl1_q.tap_sel);
    tap_hi = ctrl1_q.zero ? '0 : tap_of(cfg_i.high_first, cfg_i.high_second, ctrl1_q.tap_sel);
    prod_lo_d = rdata_i * tap_lo;
    prod_hi_d = rdata_i * tap_hi;
  end

  always_comb begin
    acc_lo_d = (ctrl2_q.first ? '0 : acc_lo_q) + $signed(prod_lo_q[COEF_W-1:0]);
    acc_hi_d = (ctrl2_q.first ? '0 : acc_hi_q) + $signed(prod_hi_q[COEF_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q     <= '0;
      ctrl2_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      if (ctrl2_q.valid && ctrl2_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    if (ctrl2_q.valid) begin
      acc_lo_q <= acc_lo_d;
      acc_hi_q <= acc_hi_d;
    end
    if (ctrl2_q.valid && ctrl2_q.last) begin
      approx_q    <= acc_lo_d;
      detail_q    <= acc_hi_d;
      index_q     <= ctrl2_q.pair;
      last_pair_q <= ctrl2_q.last_pair;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign approx_o      = approx_q;
  assign detail_o      = detail_q;
  assign coeff_index_o = index_q;
  assign last_pair_o   = last_pair_q;

endmodule

// ===== sv/wpa_seq.sv =====
module wpa_seq
  import wpa_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_accept_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [AW-1:0] mem_raddr_o,
  output mac_ctrl_t     ctrl_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [LEN_W-1:0]     fill_q, fill_d, fill_inc;
  logic [AW-1:0]        pair_q, pair_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [TAP_SEL_W-1:0] tap_q, tap_d, tap_last;
  logic                 in_accept, pair_last, tap_done;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_accept  = in_valid_i && in_ready_o;
  assign fill_inc   = fill_q + LEN_W'(1);

  assign tap_last  = (cfg_i.taps == '0) ? '0 : TAP_SEL_W'(cfg_i.taps - TAPCNT_W'(1));
  assign tap_done  = (tap_q == tap_last);
  assign pair_last = (LEN_W'(pair_q) + LEN_W'(1)) == (cfg_i.len >> 1);

  assign mem_we_o    = in_accept;
  assign mem_waddr_o = fill_q[AW-1:0];
  assign mem_raddr_o = rd_idx_q;

  always_comb begin
    ctrl_o.valid     = (state_q == ST_RUN);
    ctrl_o.first     = (tap_q == '0);
    ctrl_o.last      = tap_done;
    ctrl_o.zero      = (cfg_i.taps == '0);
    ctrl_o.tap_sel   = tap_q;
    ctrl_o.pair      = COEFF_IDX_W'(pair_q);
    ctrl_o.last_pair = pair_last;
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    pair_d   = pair_q;
    rd_idx_d = rd_idx_q;
    tap_d    = tap_q;
    case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          if (fill_inc >= cfg_i.len) begin
            fill_d   = '0;
            pair_d   = '0;
            rd_idx_d = '0;
            tap_d    = '0;
            state_d  = ST_RUN;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      ST_RUN: begin
        // The read index walks the block circularly and may wrap more than once.
        if ((LEN_W'(rd_idx_q) + LEN_W'(1)) == cfg_i.len) begin
          rd_idx_d = '0;
        end else begin
          rd_idx_d = rd_idx_q + AW'(1);
        end
        tap_d = tap_q + TAP_SEL_W'(1);
        if (tap_done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_accept_i) begin
          if (pair_last) begin
            state_d = ST_LOAD;
          end else begin
            pair_d   = pair_q + AW'(1);
            rd_idx_d = AW'((LEN_W'(pair_q) + LEN_W'(1)) << 1);
            tap_d    = '0;
            state_d  = ST_RUN;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      fill_q   <= '0;
      pair_q   <= '0;
      rd_idx_q <= '0;
      tap_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      pair_q   <= pair_d;
      rd_idx_q <= rd_idx_d;
      tap_q    <= tap_d;
    end
  end

endmodule

// ===== sv/wavelet_packet_analysis_step_top.sv =====
// One level of a periodic two-channel wavelet analysis filter bank.
// Samples arrive on in_i, one per item, in block order. While a block is
// loading, in_i.ready is high and every sample takes one cycle. The sample
// that completes the block starts the computation, and in_i.ready stays low
// until the last coefficient pair of that block has been taken on out_o.
// Each pair is the circular correlation of the block with both tap sets,
// starting at sample 2i; out_o carries approx, detail, the pair index and a
// flag on the final pair. One dual multiply-accumulate unit does both
// filters, one tap per cycle, behind a registered sample memory read and a
// product register. When the receiver stalls, the finished pair waits in
// the output register and the next pair is not started. Configuration
// writes on cfg_i are taken in any cycle and belong between blocks. Reset
// clears the fill count and the sequencer and loads the default Haar taps,
// two taps and a block length of eight; the sample memory is not cleared.
module wavelet_packet_analysis_step_top
  import wpa_pkg::*;
#(
  parameter int MAX_LEN      = MAX_LEN_DEF,
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpa_in_if.sink    in_i,
  wpa_out_if.source out_o,
  wpa_cfg_if.sink   cfg_i
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  cfg_t              cfg_s;
  mac_ctrl_t         ctrl_s;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [SAMPLE_WIDTH-1:0] mem_rdata;
  logic              out_valid;

  assign cfg_i.ready = 1'b1;

  wpa_cfg_regs #(
    .MAX_LEN (MAX_LEN),
    .MAX_TAPS(MAX_TAPS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(cfg_i.valid),
    .wr_index_i(cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg_s)
  );

  wpa_seq #(
    .MAX_LEN(MAX_LEN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_s),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_accept_i(out_valid && out_o.ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_raddr_o (mem_raddr),
    .ctrl_o      (ctrl_s)
  );

  wpa_sample_mem #(
    .DEPTH(MAX_LEN),
    .WIDTH(SAMPLE_WIDTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_i.sample),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  wpa_dual_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_s),
    .ctrl_i       (ctrl_s),
    .rdata_i      ($signed(mem_rdata)),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .approx_o     (out_o.approx),
    .detail_o     (out_o.detail),
    .coeff_index_o(out_o.coeff_index),
    .last_pair_o  (out_o.last_pair)
  );

  assign out_o.valid = out_valid;

`ifndef ASSERT_OFF
  // No sample is taken while a coefficient pair is still pending.
  a_no_load_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("sample accepted while a pair is pending");

  // Pair indexes stay inside the block.
  a_index_in_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((LEN_W'(out_o.coeff_index) << 1) < cfg_s.len))
    else $error("pair index beyond the block");

  // The final-pair flag marks exactly the pair at index L/2 - 1.
  a_last_pair_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.last_pair == ((LEN_W'(out_o.coeff_index) + LEN_W'(1)) == (cfg_s.len >> 1))))
    else $error("final pair flag mismatch");

  // A pair handed over without a stall never shows up twice in a row.
  a_no_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> !out_o.valid)
    else $error("pair presented again after acceptance");
`endif

endmodule
